// ----- src/vwpp_pkg.sv -----
// Shared types, constants and helpers of the variable-width Philox permutation.
// No dependencies; every other file uses these by scoped names.
package vwpp_pkg;

   // Fixed multipliers: round mixing constant and key schedule constant.
   localparam logic [63:0] MIX_MULT = 64'hD2B7_4407_B1CE_6E93;
   localparam logic [63:0] KEY_MULT = 64'h9E37_79B9_7F4A_7C15;

   // Register reset values.
   localparam logic [5:0]  LEFT_WIDTH_RESET  = 6'd32;
   localparam logic [5:0]  RIGHT_WIDTH_RESET = 6'd32;
   localparam logic [4:0]  ROUND_COUNT_RESET = 5'd7;
   localparam logic [63:0] KEY_SEED_RESET    = 64'd7777777;

   // Default depth of the round pipeline.
   localparam int MAX_ROUNDS_DEFAULT = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SEED    = 2'd3;

   // Static settings seen by every round stage.
   typedef struct packed {
      logic [5:0]  lw;    // left width, 1..32
      logic [5:0]  rw;    // right width, 1..32
      logic [63:0] base;  // key_seed * KEY_MULT, wrapped
   } cfg_type;

   // One beat travelling between round stages.
   typedef struct packed {
      logic        valid;
      logic [31:0] left;
      logic [31:0] right;
   } beat_type;

   // Limit a width to 1..32.
   function automatic logic [5:0] clamp_width(input logic [5:0] w);
      logic [5:0] r;
      if (w == 6'd0) begin
         r = 6'd1;
      end else if (w > 6'd32) begin
         r = 6'd32;
      end else begin
         r = w;
      end
      return r;
   endfunction

   // Low-bit mask for a width of 1..32; 32 gives all ones.
   function automatic logic [31:0] width_mask(input logic [5:0] w);
      logic [31:0] m;
      if (w >= 6'd32) begin
         m = '1;
      end else begin
         m = (32'd1 << w) - 32'd1;
      end
      return m;
   endfunction

endpackage

// ----- src/vwpp_csr.sv -----
// Configuration registers and round key base precompute.
// Depends on vwpp_pkg.
module vwpp_csr #(
   parameter int MAX_ROUNDS = vwpp_pkg::MAX_ROUNDS_DEFAULT,
   parameter int CNT_W      = $clog2(MAX_ROUNDS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [vwpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vwpp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output vwpp_pkg::cfg_type                cfg,
   output logic [CNT_W-1:0]                 rounds
);

   localparam logic [31:0] KEY_LO  = vwpp_pkg::KEY_MULT[31:0];
   localparam logic [31:0] KEY_HI  = vwpp_pkg::KEY_MULT[63:32];
   localparam logic [63:0] SEED_RST = vwpp_pkg::KEY_SEED_RESET;
   localparam logic [63:0] PLL_RST  = 64'(SEED_RST[31:0]) * 64'(KEY_LO);
   localparam logic [63:0] PA_FULL  = 64'(SEED_RST[31:0]) * 64'(KEY_HI);
   localparam logic [63:0] PB_FULL  = 64'(SEED_RST[63:32]) * 64'(KEY_LO);
   localparam logic [31:0] PA_RST   = PA_FULL[31:0];
   localparam logic [31:0] PB_RST   = PB_FULL[31:0];
   localparam logic [63:0] BASE_RST = PLL_RST + {PA_RST + PB_RST, 32'd0};
   localparam int          RND_RST_INT =
      (int'(vwpp_pkg::ROUND_COUNT_RESET) > MAX_ROUNDS) ? MAX_ROUNDS
                                                        : int'(vwpp_pkg::ROUND_COUNT_RESET);
   localparam logic [CNT_W-1:0] RND_RST = CNT_W'(RND_RST_INT);

   logic [5:0]       lw_ff, lw_in;
   logic [5:0]       rw_ff, rw_in;
   logic [CNT_W-1:0] rnd_ff, rnd_in;
   logic [63:0]      pll_ff, pll_in;
   logic [31:0]      pa_ff, pa_in;
   logic [31:0]      pb_ff, pb_in;
   logic [63:0]      base_ff, base_in;
   logic [4:0]       rc;
   logic [63:0]      pa_full, pb_full;

   // Decode writes; clamp widths and round count as they land
   always_comb begin
      lw_in   = lw_ff;
      rw_in   = rw_ff;
      rnd_in  = rnd_ff;
      pll_in  = pll_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      rc      = csr_wdata[4:0];
      pa_full = 64'(csr_wdata[31:0]) * 64'(KEY_HI);
      pb_full = 64'(csr_wdata[63:32]) * 64'(KEY_LO);
      if (csr_wr_en) begin
         unique case (csr_index)
            vwpp_pkg::CSR_LEFT_WIDTH: begin
               lw_in = vwpp_pkg::clamp_width(csr_wdata[5:0]);
            end
            vwpp_pkg::CSR_RIGHT_WIDTH: begin
               rw_in = vwpp_pkg::clamp_width(csr_wdata[5:0]);
            end
            vwpp_pkg::CSR_ROUND_COUNT: begin
               if (rc == 5'd0) begin
                  rnd_in = CNT_W'(1);
               end else if (int'(rc) > MAX_ROUNDS) begin
                  rnd_in = CNT_W'(MAX_ROUNDS);
               end else begin
                  rnd_in = CNT_W'(rc);
               end
            end
            vwpp_pkg::CSR_KEY_SEED: begin
               // Split the wrapped 64x64 product into 32x32 partial products
               pll_in = 64'(csr_wdata[31:0]) * 64'(KEY_LO);
               pa_in  = pa_full[31:0];
               pb_in  = pb_full[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Combine the registered partial products of a seed write
   assign base_in = pll_ff + {pa_ff + pb_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff   <= vwpp_pkg::LEFT_WIDTH_RESET;
         rw_ff   <= vwpp_pkg::RIGHT_WIDTH_RESET;
         rnd_ff  <= RND_RST;
         pll_ff  <= PLL_RST;
         pa_ff   <= PA_RST;
         pb_ff   <= PB_RST;
         base_ff <= BASE_RST;
      end else begin
         lw_ff   <= lw_in;
         rw_ff   <= rw_in;
         rnd_ff  <= rnd_in;
         pll_ff  <= pll_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         base_ff <= base_in;
      end
   end

   assign cfg.lw   = lw_ff;
   assign cfg.rw   = rw_ff;
   assign cfg.base = base_ff;
   assign rounds   = rnd_ff;

endmodule

// ----- src/vwpp_round.sv -----
// One mixing round as two register stages: multiply, then add/xor/shift.
// Depends on vwpp_pkg.
module vwpp_round #(
   parameter int MAX_ROUNDS  = vwpp_pkg::MAX_ROUNDS_DEFAULT,
   parameter int CNT_W       = $clog2(MAX_ROUNDS + 1),
   parameter int ROUND_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  vwpp_pkg::cfg_type   cfg,
   input  logic [CNT_W-1:0]    rounds,
   input  vwpp_pkg::beat_type  beat_in,
   output vwpp_pkg::beat_type  beat_out
);

   localparam logic [31:0] MIX_LO = vwpp_pkg::MIX_MULT[31:0];
   localparam logic [31:0] MIX_HI = vwpp_pkg::MIX_MULT[63:32];

   // Stage A: partial products of MIX_MULT * left
   logic        a_valid_ff, a_valid_in;
   logic [31:0] a_left_ff;
   logic [31:0] a_right_ff;
   logic [63:0] a_plo_ff, a_plo_in;
   logic [31:0] a_phi_ff, a_phi_in;
   logic [63:0] phi_full;

   // Stage B: round output
   logic        b_valid_ff;
   logic [31:0] b_left_ff, b_left_in;
   logic [31:0] b_right_ff, b_right_in;

   logic        active;
   logic [31:0] hi, lo, key, mixed;
   logic [63:0] key_sum;
   logic [5:0]  d_rl, d_lr;

   assign a_valid_in = beat_in.valid;
   assign a_plo_in   = 64'(beat_in.left) * 64'(MIX_LO);
   assign phi_full   = 64'(beat_in.left) * 64'(MIX_HI);
   assign a_phi_in   = phi_full[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_left_ff  <= beat_in.left;
         a_right_ff <= beat_in.right;
         a_plo_ff   <= a_plo_in;
         a_phi_ff   <= a_phi_in;
      end
   end

   // Finish the wrapped product, build the round key, mix the halves; inactive rounds pass the beat
   always_comb begin
      active  = CNT_W'(ROUND_INDEX) < rounds;
      hi      = a_plo_ff[63:32] + a_phi_ff;
      lo      = a_plo_ff[31:0];
      key_sum = cfg.base + 64'(ROUND_INDEX);
      key     = key_sum[63:32];
      d_rl    = cfg.rw - cfg.lw;
      d_lr    = cfg.lw - cfg.rw;
      if (cfg.rw >= cfg.lw) begin
         mixed = (lo << d_rl) | (a_right_ff >> cfg.lw);
      end else begin
         mixed = (lo >> d_lr) | (a_right_ff << d_lr);
      end
      if (active) begin
         b_left_in  = (hi ^ key ^ a_right_ff) & vwpp_pkg::width_mask(cfg.lw);
         b_right_in = mixed & vwpp_pkg::width_mask(cfg.rw);
      end else begin
         b_left_in  = a_left_ff;
         b_right_in = a_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_left_ff  <= b_left_in;
         b_right_ff <= b_right_in;
      end
   end

   assign beat_out.valid = b_valid_ff;
   assign beat_out.left  = b_left_ff;
   assign beat_out.right = b_right_ff;

endmodule

// ----- src/variable_width_philox_permutation.sv -----
// Top level of the variable-width Philox permutation: input split, round chain, output.
// Depends on vwpp_pkg, vwpp_csr and vwpp_round.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+-------------------------------
//   req     | req_valid, req_ready, req_in_value      | one value to permute per beat
//   rsp     | rsp_valid, rsp_ready, rsp_out_value     | one permuted value per beat
//   csr     | csr_wr_en, csr_index, csr_wdata         | one register write per cycle
//
// Accepts one beat per cycle while req_ready is high. From accept to rsp_valid a beat passes
// one input stage, two stages per round (32x32 multiplies, then add/xor/shift), and the
// output register. Rounds past round_count pass their beat through unchanged.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// The chain advances whenever its last stage is empty or the output register drains.
module variable_width_philox_permutation #(
   parameter int MAX_ROUNDS = vwpp_pkg::MAX_ROUNDS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [63:0]                      req_in_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [63:0]                      rsp_out_value,
   input  logic                             csr_wr_en,
   input  logic [vwpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vwpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

   vwpp_pkg::cfg_type  cfg;
   logic [CNT_W-1:0]   rounds;
   vwpp_pkg::beat_type beat [MAX_ROUNDS+1];

   logic        en;
   logic        out_free;
   logic        s0_valid_ff;
   logic [31:0] s0_left_ff, s0_left_in;
   logic [31:0] s0_right_ff, s0_right_in;
   logic [63:0] shifted;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff, out_value_in;

   vwpp_csr #(
      .MAX_ROUNDS (MAX_ROUNDS),
      .CNT_W      (CNT_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .rounds    (rounds)
   );

   // Advance the chain unless the last stage holds a beat the output cannot take
   assign out_free  = !out_valid_ff || rsp_ready;
   assign en        = out_free || !beat[MAX_ROUNDS].valid;
   assign req_ready = en;

   // Split the input into left and right halves
   always_comb begin
      shifted     = req_in_value >> cfg.rw;
      s0_left_in  = shifted[31:0] & vwpp_pkg::width_mask(cfg.lw);
      s0_right_in = req_in_value[31:0] & vwpp_pkg::width_mask(cfg.rw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_left_ff  <= s0_left_in;
         s0_right_ff <= s0_right_in;
      end
   end

   assign beat[0].valid = s0_valid_ff;
   assign beat[0].left  = s0_left_ff;
   assign beat[0].right = s0_right_ff;

   // Round chain
   for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
      vwpp_round #(
         .MAX_ROUNDS  (MAX_ROUNDS),
         .CNT_W       (CNT_W),
         .ROUND_INDEX (r)
      ) u_round (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cfg      (cfg),
         .rounds   (rounds),
         .beat_in  (beat[r]),
         .beat_out (beat[r+1])
      );
   end

   // Join the halves and hold the result until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      if (out_free) begin
         out_valid_in = beat[MAX_ROUNDS].valid;
         out_value_in = ({32'd0, beat[MAX_ROUNDS].left} << cfg.rw)
                        | {32'd0, beat[MAX_ROUNDS].right};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_value = out_value_ff;

endmodule

// ----- src/vwpp_checker.sv -----
// Port-level checks of the variable-width Philox permutation, bound to the top level.
// Depends on vwpp_pkg and variable_width_philox_permutation.
module vwpp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [63:0]                      req_in_value,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [63:0]                      rsp_out_value,
   input logic                             csr_wr_en,
   input logic [vwpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [vwpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [5:0] lw_ff, lw_in;
   logic [5:0] rw_ff, rw_in;
   logic [6:0] span;

   // Track the effective widths from the write port
   always_comb begin
      lw_in = lw_ff;
      rw_in = rw_ff;
      if (csr_wr_en && csr_index == vwpp_pkg::CSR_LEFT_WIDTH) begin
         lw_in = vwpp_pkg::clamp_width(csr_wdata[5:0]);
      end
      if (csr_wr_en && csr_index == vwpp_pkg::CSR_RIGHT_WIDTH) begin
         rw_in = vwpp_pkg::clamp_width(csr_wdata[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= vwpp_pkg::LEFT_WIDTH_RESET;
         rw_ff <= vwpp_pkg::RIGHT_WIDTH_RESET;
      end else begin
         lw_ff <= lw_in;
         rw_ff <= rw_in;
      end
   end

   assign span = 7'(lw_ff) + 7'(rw_ff);

   // Input beat holds while refused
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_value))
      else $error("input beat changed while refused");

   // Result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value))
      else $error("result beat changed while stalled");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // Input is refused only behind a stalled result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output back-pressure");

   // Result stays inside the configured range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_value >> span) == 64'd0)
      else $error("result wider than left_width + right_width");

endmodule

bind variable_width_philox_permutation vwpp_checker u_vwpp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_in_value  (req_in_value),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_value (rsp_out_value),
   .csr_wr_en     (csr_wr_en),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);
